FILE: design/scpwm_pkg.sv
// Shared types, register map constants and helpers for the sixteen-channel
// PWM register device. No dependencies.
package scpwm_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int COUNT_BITS   = 12;
  localparam int CHAN_BYTES   = 64;
  localparam int CHAN_IDX_W   = $clog2(CHAN_BYTES);
  localparam int PWM_W        = 16;

  localparam logic [7:0] ADDR_MODE1    = 8'h00;
  localparam logic [7:0] ADDR_MODE2    = 8'h01;
  localparam logic [7:0] ADDR_LED_BASE = 8'h06;
  localparam logic [7:0] ADDR_LED_LAST = 8'(6 + CHAN_BYTES - 1);
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

  localparam int BIT_SLEEP   = 4;
  localparam int BIT_AUTOINC = 5;
  localparam int BIT_RESTART = 7;
  localparam int BIT_INVRT   = 4;
  localparam int BIT_FULL    = 4;

  localparam logic [7:0] MODE2_MASK    = 8'h1F;
  localparam logic [7:0] PRESCALE_MIN  = 8'h03;
  localparam logic [7:0] MODE1_RESET   = 8'h11;
  localparam logic [7:0] MODE2_RESET   = 8'h04;
  localparam logic [7:0] PRESCALE_RESET = 8'h1E;
  localparam logic [7:0] OFF_H_RESET   = 8'h10;

  typedef enum logic [1:0] {
    ACT_ADDR  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef logic [CHAN_BYTES-1:0][7:0] chan_bytes_t;

  function automatic logic [7:0] chan_reset_val(input logic [CHAN_IDX_W-1:0] idx);
    return (idx[1:0] == 2'd3) ? OFF_H_RESET : 8'h00;
  endfunction

endpackage

FILE: design/sixteen_channel_pwm_register_device.sv
// Top level of the sixteen-channel PWM register device: bus register file,
// prescale divider, PWM counter and readback memory. Depends on scpwm_pkg, scpwm_level.
// An input beat passes through the input register and then the result register
// before its result beat can be taken.
// Throughput: one beat per cycle while the result side does not stall; the input
// register and result register are separated so a new beat is taken while a result waits.
// Reset is synchronous and loads the datasheet register defaults at once.
// There is no clearing pass; readback of unwritten channel bytes uses valid bits.
module sixteen_channel_pwm_register_device (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [7:0]                      in_bus_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_read_data,
  output logic [scpwm_pkg::PWM_W-1:0]     out_pwm_out,
  output logic                            out_sleeping
);

  localparam int IW = scpwm_pkg::CHAN_IDX_W;
  localparam int CW = scpwm_pkg::COUNT_BITS;

  logic                              in_vld_r;
  scpwm_pkg::action_t                act_r;
  logic [7:0]                        byte_r;

  logic [7:0]                        ptr_r, ptr_nxt;
  logic [7:0]                        mode1_r, mode1_nxt;
  logic [7:0]                        mode2_r, mode2_nxt;
  logic [7:0]                        presc_r, presc_nxt;
  logic [7:0]                        div_r, div_nxt;
  logic [scpwm_pkg::COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  scpwm_pkg::chan_bytes_t            chan_r, chan_nxt;

  logic [7:0]                        mem [scpwm_pkg::CHAN_BYTES];
  logic [scpwm_pkg::CHAN_BYTES-1:0]  mvld_r;
  logic [7:0]                        rd_mem_r;
  logic                              rd_vld_r;
  logic                              rd_byp_r;
  logic [7:0]                        rd_wdata_r;

  logic                              out_vld_r;
  logic [7:0]                        out_rd_r;
  logic [scpwm_pkg::PWM_W-1:0]       out_pwm_r;
  logic                              out_sleep_r;

  logic                              adv;
  logic                              go;
  logic                              is_chan;
  logic [7:0]                        ptr_off;
  logic [IW-1:0]                     widx;
  logic                              we;
  logic [7:0]                        nxt_off;
  logic [IW-1:0]                     ridx;
  logic [7:0]                        chan_rd;
  logic [7:0]                        rd_val;
  logic [scpwm_pkg::PWM_W-1:0]       pwm_nxt;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign go       = in_vld_r && adv;

  assign is_chan = (ptr_r >= scpwm_pkg::ADDR_LED_BASE) && (ptr_r <= scpwm_pkg::ADDR_LED_LAST);
  assign ptr_off = ptr_r - scpwm_pkg::ADDR_LED_BASE;
  assign widx    = ptr_off[IW-1:0];
  assign we      = go && (act_r == scpwm_pkg::ACT_WRITE) && is_chan;
  assign nxt_off = ptr_nxt - scpwm_pkg::ADDR_LED_BASE;
  assign ridx    = nxt_off[IW-1:0];

  always_comb begin
    if (rd_byp_r) begin
      chan_rd = rd_wdata_r;
    end else if (rd_vld_r) begin
      chan_rd = rd_mem_r;
    end else begin
      chan_rd = scpwm_pkg::chan_reset_val(widx);
    end
    if (ptr_r == scpwm_pkg::ADDR_MODE1) begin
      rd_val = mode1_r;
    end else if (ptr_r == scpwm_pkg::ADDR_MODE2) begin
      rd_val = mode2_r;
    end else if (ptr_r == scpwm_pkg::ADDR_PRESCALE) begin
      rd_val = presc_r;
    end else if (is_chan) begin
      rd_val = chan_rd;
    end else begin
      rd_val = 8'h00;
    end
  end

  always_comb begin
    ptr_nxt   = ptr_r;
    mode1_nxt = mode1_r;
    mode2_nxt = mode2_r;
    presc_nxt = presc_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    chan_nxt  = chan_r;
    if (go) begin
      case (act_r)
        scpwm_pkg::ACT_ADDR: begin
          ptr_nxt = byte_r;
        end
        scpwm_pkg::ACT_WRITE, scpwm_pkg::ACT_READ: begin
          if (act_r == scpwm_pkg::ACT_WRITE) begin
            if (ptr_r == scpwm_pkg::ADDR_MODE1) begin
              mode1_nxt = byte_r;
              mode1_nxt[scpwm_pkg::BIT_RESTART] = 1'b0;
            end else if (ptr_r == scpwm_pkg::ADDR_MODE2) begin
              mode2_nxt = byte_r & scpwm_pkg::MODE2_MASK;
            end else if (ptr_r == scpwm_pkg::ADDR_PRESCALE) begin
              if (mode1_r[scpwm_pkg::BIT_SLEEP]) begin
                presc_nxt = (byte_r < scpwm_pkg::PRESCALE_MIN) ? scpwm_pkg::PRESCALE_MIN
                                                                : byte_r;
              end
            end else if (is_chan) begin
              chan_nxt[widx] = byte_r;
            end
          end
          if (mode1_nxt[scpwm_pkg::BIT_AUTOINC]) begin
            ptr_nxt = (ptr_r == scpwm_pkg::ADDR_LED_LAST) ? scpwm_pkg::ADDR_MODE1
                                                          : ptr_r + 8'd1;
          end
        end
        scpwm_pkg::ACT_TICK: begin
          if (!mode1_r[scpwm_pkg::BIT_SLEEP]) begin
            if (div_r >= presc_r) begin
              div_nxt = 8'h00;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              div_nxt = div_r + 8'd1;
            end
          end
        end
        default: begin
          ptr_nxt = ptr_r;
        end
      endcase
    end
  end

  scpwm_level u_level (
    .chan   (chan_nxt),
    .cnt    (cnt_nxt),
    .invert (mode2_nxt[scpwm_pkg::BIT_INVRT]),
    .pwm    (pwm_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ptr_r     <= 8'h00;
      mode1_r   <= scpwm_pkg::MODE1_RESET;
      mode2_r   <= scpwm_pkg::MODE2_RESET;
      presc_r   <= scpwm_pkg::PRESCALE_RESET;
      div_r     <= 8'h00;
      cnt_r     <= '0;
      for (int i = 0; i < scpwm_pkg::CHAN_BYTES; i++) begin
        chan_r[i] <= scpwm_pkg::chan_reset_val(IW'(i));
      end
      mvld_r    <= '0;
      rd_vld_r  <= 1'b0;
      rd_byp_r  <= 1'b0;
    end else begin
      in_vld_r  <= in_stall ? 1'b1 : in_valid;
      if (adv) begin
        out_vld_r <= go;
      end
      ptr_r     <= ptr_nxt;
      mode1_r   <= mode1_nxt;
      mode2_r   <= mode2_nxt;
      presc_r   <= presc_nxt;
      div_r     <= div_nxt;
      cnt_r     <= cnt_nxt;
      chan_r    <= chan_nxt;
      if (we) begin
        mvld_r[widx] <= 1'b1;
      end
      rd_vld_r  <= mvld_r[ridx];
      rd_byp_r  <= we && (widx == ridx);
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      act_r  <= scpwm_pkg::action_t'(in_action);
      byte_r <= in_bus_byte;
    end
    if (go) begin
      out_rd_r    <= (act_r == scpwm_pkg::ACT_READ) ? rd_val : 8'h00;
      out_pwm_r   <= pwm_nxt;
      out_sleep_r <= mode1_nxt[scpwm_pkg::BIT_SLEEP];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= byte_r;
    end
    rd_mem_r   <= mem[ridx];
    rd_wdata_r <= byte_r;
  end

  assign out_valid     = out_vld_r;
  assign out_read_data = out_rd_r;
  assign out_pwm_out   = out_pwm_r;
  assign out_sleeping  = out_sleep_r;

  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !mode1_r[scpwm_pkg::BIT_RESTART])
    else $error("MODE1 restart bit stored as one");

  a_prescale_min: assert property (@(posedge clk) disable iff (!rst_n)
    presc_r >= scpwm_pkg::PRESCALE_MIN)
    else $error("prescaler below minimum");

  a_sleep_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode1_r[scpwm_pkg::BIT_SLEEP] |=> $stable(cnt_r) && $stable(div_r))
    else $error("counter moved while asleep");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_vld_r && out_stall && in_vld_r)
    else $error("input stalled with room in the result register");

endmodule

FILE: design/scpwm_level.sv
// Per-channel output level: on/off window compare, full-on/full-off and inversion.
// Depends on scpwm_pkg.
module scpwm_level (
  input  scpwm_pkg::chan_bytes_t               chan,
  input  logic [scpwm_pkg::COUNT_BITS-1:0]     cnt,
  input  logic                                 invert,
  output logic [scpwm_pkg::PWM_W-1:0]          pwm
);

  function automatic logic chan_level(input logic [7:0] on_l, input logic [7:0] on_h,
                                      input logic [7:0] off_l, input logic [7:0] off_h,
                                      input logic [scpwm_pkg::COUNT_BITS-1:0] c);
    logic [15:0] on_w;
    logic [15:0] off_w;
    logic [scpwm_pkg::COUNT_BITS-1:0] on_v;
    logic [scpwm_pkg::COUNT_BITS-1:0] off_v;
    logic lvl;
    on_w  = {4'h0, on_h[3:0], on_l};
    off_w = {4'h0, off_h[3:0], off_l};
    on_v  = on_w[scpwm_pkg::COUNT_BITS-1:0];
    off_v = off_w[scpwm_pkg::COUNT_BITS-1:0];
    if (off_h[scpwm_pkg::BIT_FULL]) begin
      lvl = 1'b0;
    end else if (on_h[scpwm_pkg::BIT_FULL]) begin
      lvl = 1'b1;
    end else if (on_v < off_v) begin
      lvl = (c >= on_v) && (c < off_v);
    end else if (on_v > off_v) begin
      lvl = (c >= on_v) || (c < off_v);
    end else begin
      lvl = 1'b0;
    end
    return lvl;
  endfunction

  always_comb begin
    pwm = '0;
    for (int n = 0; n < scpwm_pkg::NUM_CHANNELS; n++) begin
      pwm[n] = invert ^ chan_level(chan[4*n], chan[4*n+1], chan[4*n+2], chan[4*n+3], cnt);
    end
  end

endmodule

FILE: test/pwm_device_checker.sv
`timescale 1ns / 100ps
// Checker for the sixteen-channel PWM register device: it watches both channels,
// predicts every result beat and compares it. Depends on scpwm_pkg.
module pwm_device_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_bus_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [7:0]                  out_read_data,
  input  logic [scpwm_pkg::PWM_W-1:0] out_pwm_out,
  input  logic                        out_sleeping,
  output int                          mismatches,
  output int                          pending
);

  typedef struct packed {
    logic [7:0]                  read_data;
    logic [scpwm_pkg::PWM_W-1:0] pwm_out;
    logic                        sleeping;
  } pwm_result_t;

  logic [7:0]  dev_ptr;
  logic [7:0]  dev_mode1;
  logic [7:0]  dev_mode2;
  logic [7:0]  dev_prescale;
  logic [7:0]  dev_div;
  logic [15:0] dev_count;
  logic [7:0]  dev_chan [scpwm_pkg::CHAN_BYTES];

  pwm_result_t result_q [$];

  task automatic predict_beat(input scpwm_pkg::action_t act, input logic [7:0] b,
                              output pwm_result_t res);
    logic [15:0] mask;
    logic [15:0] cnt;
    logic [15:0] on_cnt;
    logic [15:0] off_cnt;
    logic        level;
    logic [7:0]  rd;
    logic [7:0]  off;
    logic        in_led;
    int          base;
    int          n;
    rd = 8'h00;
    mask = 16'((32'd1 << scpwm_pkg::COUNT_BITS) - 1);
    off = dev_ptr - scpwm_pkg::ADDR_LED_BASE;
    in_led = (dev_ptr >= scpwm_pkg::ADDR_LED_BASE) && (dev_ptr <= scpwm_pkg::ADDR_LED_LAST);
    case (act)
      scpwm_pkg::ACT_ADDR: begin
        dev_ptr = b;
      end
      scpwm_pkg::ACT_WRITE, scpwm_pkg::ACT_READ: begin
        if (act == scpwm_pkg::ACT_READ) begin
          if (dev_ptr == scpwm_pkg::ADDR_MODE1) rd = dev_mode1;
          else if (dev_ptr == scpwm_pkg::ADDR_MODE2) rd = dev_mode2;
          else if (dev_ptr == scpwm_pkg::ADDR_PRESCALE) rd = dev_prescale;
          else if (in_led) rd = dev_chan[off[scpwm_pkg::CHAN_IDX_W-1:0]];
        end else begin
          if (dev_ptr == scpwm_pkg::ADDR_MODE1) begin
            dev_mode1 = b;
            dev_mode1[scpwm_pkg::BIT_RESTART] = 1'b0;
          end else if (dev_ptr == scpwm_pkg::ADDR_MODE2) begin
            dev_mode2 = b & scpwm_pkg::MODE2_MASK;
          end else if (dev_ptr == scpwm_pkg::ADDR_PRESCALE) begin
            if (dev_mode1[scpwm_pkg::BIT_SLEEP])
              dev_prescale = (b < scpwm_pkg::PRESCALE_MIN) ? scpwm_pkg::PRESCALE_MIN : b;
          end else if (in_led) begin
            dev_chan[off[scpwm_pkg::CHAN_IDX_W-1:0]] = b;
          end
        end
        if (dev_mode1[scpwm_pkg::BIT_AUTOINC])
          dev_ptr = (dev_ptr == scpwm_pkg::ADDR_LED_LAST) ? scpwm_pkg::ADDR_MODE1
                                                          : dev_ptr + 8'd1;
      end
      default: begin
        if (!dev_mode1[scpwm_pkg::BIT_SLEEP]) begin
          if (dev_div >= dev_prescale) begin
            dev_div = 8'd0;
            dev_count = (dev_count + 16'd1) & mask;
          end else begin
            dev_div = dev_div + 8'd1;
          end
        end
      end
    endcase

    res.read_data = rd;
    res.sleeping = dev_mode1[scpwm_pkg::BIT_SLEEP];
    res.pwm_out = '0;
    cnt = dev_count & mask;
    for (n = 0; n < scpwm_pkg::NUM_CHANNELS; n++) begin
      base = (4 * n) % scpwm_pkg::CHAN_BYTES;
      on_cnt = {4'h0, dev_chan[base+1][3:0], dev_chan[base]} & mask;
      off_cnt = {4'h0, dev_chan[base+3][3:0], dev_chan[base+2]} & mask;
      if (dev_chan[base+3][scpwm_pkg::BIT_FULL]) level = 1'b0;
      else if (dev_chan[base+1][scpwm_pkg::BIT_FULL]) level = 1'b1;
      else if (on_cnt < off_cnt) level = (cnt >= on_cnt) && (cnt < off_cnt);
      else if (on_cnt > off_cnt) level = (cnt >= on_cnt) || (cnt < off_cnt);
      else level = 1'b0;
      if (dev_mode2[scpwm_pkg::BIT_INVRT]) level = !level;
      res.pwm_out[n] = level;
    end
  endtask

  always @(posedge clk) begin : watch
    pwm_result_t want;
    pwm_result_t got;
    int i;
    if (!rst_n) begin
      dev_ptr = 8'h00;
      dev_mode1 = scpwm_pkg::MODE1_RESET;
      dev_mode2 = scpwm_pkg::MODE2_RESET;
      dev_prescale = scpwm_pkg::PRESCALE_RESET;
      dev_div = 8'd0;
      dev_count = 16'd0;
      for (i = 0; i < scpwm_pkg::CHAN_BYTES; i++)
        dev_chan[i] = (i % 4 == 3) ? scpwm_pkg::OFF_H_RESET : 8'h00;
      result_q.delete();
    end else begin
      // A result beat answers an input beat taken at an earlier edge, so it is
      // matched before this edge's input beat is predicted.
      if (out_valid && !out_stall) begin
        got.read_data = out_read_data;
        got.pwm_out = out_pwm_out;
        got.sleeping = out_sleeping;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want.read_data, got.read_data);
            mismatches++;
          end
          if (got.pwm_out !== want.pwm_out) begin
            $display("%0t: pwm_out mismatch: expected %h, actual %h",
                     $time, want.pwm_out, got.pwm_out);
            mismatches++;
          end
          if (got.sleeping !== want.sleeping) begin
            $display("%0t: sleeping mismatch: expected %b, actual %b",
                     $time, want.sleeping, got.sleeping);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_beat(scpwm_pkg::action_t'(in_action), in_bus_byte, want);
        result_q.push_back(want);
      end
    end
    pending <= result_q.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Top of the testbench for the sixteen-channel PWM register device: clock, reset,
// bus and tick stimulus, result-side stalls and verdict. Depends on scpwm_pkg,
// the device and pwm_device_checker.
module tb;

  localparam int CYCLE_LIMIT = 600000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic [1:0]                  in_action = scpwm_pkg::ACT_TICK;
  logic [7:0]                  in_bus_byte = 8'h00;
  logic                        out_stall = 1'b0;
  logic                        in_stall;
  logic                        out_valid;
  logic [7:0]                  out_read_data;
  logic [scpwm_pkg::PWM_W-1:0] out_pwm_out;
  logic                        out_sleeping;

  int mismatches;
  int pending;
  int cycles = 0;
  int beats_sent = 0;
  int stall_hold = 0;
  bit calm = 1'b0;

  always #1 clk = ~clk;

  sixteen_channel_pwm_register_device dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_bus_byte  (in_bus_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data),
    .out_pwm_out  (out_pwm_out),
    .out_sleeping (out_sleeping)
  );

  pwm_device_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_bus_byte  (in_bus_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data),
    .out_pwm_out  (out_pwm_out),
    .out_sleeping (out_sleeping),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] count_high_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 99) >= 25) b[3:0] = 4'h0;
    b[scpwm_pkg::BIT_FULL] = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 99) >= 20) b[7:5] = 3'd0;
    return b;
  endfunction

  function automatic logic [7:0] mode1_byte(input bit sleep);
    logic [7:0] b;
    b = 8'($urandom);
    b[scpwm_pkg::BIT_AUTOINC] = ($urandom_range(0, 9) != 0);
    b[scpwm_pkg::BIT_SLEEP] = sleep;
    return b;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin : result_stalls
    int len;
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      len = gap_len();
      out_stall <= (len != 0);
      stall_hold <= (len != 0) ? len - 1 : 0;
    end
  end

  task automatic send_beat(input scpwm_pkg::action_t act, input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_bus_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [7:0] addr, input logic [7:0] value);
    send_beat(scpwm_pkg::ACT_ADDR, addr);
    send_beat(scpwm_pkg::ACT_WRITE, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int r;
    int n;
    int k;
    int ch;
    bit mid_drained;
    logic [7:0] addr;
    logic [7:0] value;
    mid_drained = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, prescaler clamp while asleep and an unmapped read.
    send_beat(scpwm_pkg::ACT_READ, 8'hFF);
    write_reg(scpwm_pkg::ADDR_PRESCALE, 8'h00);
    send_beat(scpwm_pkg::ACT_READ, 8'h00);
    send_beat(scpwm_pkg::ACT_ADDR, scpwm_pkg::ADDR_LED_LAST + 8'd1);
    send_beat(scpwm_pkg::ACT_READ, 8'h00);
    // Reserved MODE2 bits and inversion; restart bit cleared while waking.
    write_reg(scpwm_pkg::ADDR_MODE2, 8'hFF);
    write_reg(scpwm_pkg::ADDR_MODE1, 8'hA0);
    // Prescaler write while awake is dropped; the pointer then wraps past 0xFF.
    write_reg(scpwm_pkg::ADDR_PRESCALE, 8'h80);
    send_beat(scpwm_pkg::ACT_READ, 8'h00);
    send_beat(scpwm_pkg::ACT_READ, 8'h00);
    // Auto-increment rolls from the last channel register to MODE1.
    write_reg(scpwm_pkg::ADDR_LED_LAST, scpwm_pkg::OFF_H_RESET);
    send_beat(scpwm_pkg::ACT_READ, 8'h00);
    // Channel 0 full on, channel 1 a wrapping window, channel 2 ON equal to OFF.
    send_beat(scpwm_pkg::ACT_ADDR, scpwm_pkg::ADDR_LED_BASE);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h00);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h10);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h00);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h00);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h05);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h00);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h02);
    send_beat(scpwm_pkg::ACT_WRITE, 8'h00);
    write_reg(scpwm_pkg::ADDR_LED_BASE + 8'd11, 8'h00);
    repeat (5) send_beat(scpwm_pkg::ACT_TICK, 8'h00);
    wait_drained();

    while (beats_sent < 900) begin
      if (!mid_drained && beats_sent >= 450) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        ch = $urandom_range(0, scpwm_pkg::NUM_CHANNELS - 1);
        addr = scpwm_pkg::ADDR_LED_BASE + 8'(4 * ch);
        if ($urandom_range(0, 9) == 0) addr = addr + 8'($urandom_range(1, 3));
        send_beat(scpwm_pkg::ACT_ADDR, addr);
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          send_beat(scpwm_pkg::ACT_WRITE, (k % 2 == 0) ? 8'($urandom) : count_high_byte());
      end else if (r < 45) begin
        if ($urandom_range(0, 9) < 7) addr = 8'($urandom_range(0, scpwm_pkg::ADDR_LED_LAST));
        else addr = 8'($urandom);
        send_beat(scpwm_pkg::ACT_ADDR, addr);
        n = $urandom_range(1, 8);
        repeat (n) send_beat(scpwm_pkg::ACT_READ, 8'($urandom));
      end else if (r < 70) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 600) : $urandom_range(1, 40);
        repeat (n) send_beat(scpwm_pkg::ACT_TICK, 8'($urandom));
      end else if (r < 78) begin
        write_reg(scpwm_pkg::ADDR_MODE1, mode1_byte(1'b1));
        k = $urandom_range(0, 3);
        if (k == 0) value = 8'($urandom_range(0, 4));
        else if (k == 1) value = 8'hFF;
        else value = 8'($urandom);
        write_reg(scpwm_pkg::ADDR_PRESCALE, value);
        write_reg(scpwm_pkg::ADDR_MODE1, mode1_byte($urandom_range(0, 4) == 0));
      end else if (r < 85) begin
        write_reg(scpwm_pkg::ADDR_MODE1, mode1_byte($urandom_range(0, 4) == 0));
      end else if (r < 90) begin
        write_reg(scpwm_pkg::ADDR_MODE2, 8'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_beat(scpwm_pkg::action_t'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    // A back-to-back tick run at the fastest prescale with no result stalls.
    write_reg(scpwm_pkg::ADDR_MODE1, 8'h30);
    write_reg(scpwm_pkg::ADDR_PRESCALE, 8'h02);
    write_reg(scpwm_pkg::ADDR_MODE1, 8'h20);
    calm = 1'b1;
    repeat (64) send_beat(scpwm_pkg::ACT_TICK, 8'($urandom));
    calm = 1'b0;
    repeat (6) send_beat(scpwm_pkg::ACT_READ, 8'($urandom));

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
